// File: src/tea_pkg.sv
// Shared types, constants and round function for the TEA block cipher.
`timescale 1ns / 1ps
package tea_pkg;

    localparam int          TEA_ROUND_PAIRS = 32;
    localparam logic [31:0] TEA_DELTA       = 32'h9E3779B9;
    localparam int          CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    typedef struct packed {
        logic        opcode;
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic        last_block;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_left;
        logic [31:0] out_right;
        logic        out_last;
    } t_out_word;

    // block state as it moves down the cell chain
    typedef struct packed {
        t_op         mode;
        logic [31:0] v0;
        logic [31:0] v1;
        logic        last;
    } t_blk;

    // round constant after k steps, modulo 2^32 (elaboration only)
    function automatic logic [31:0] sum_at(input int k);
        logic [63:0] p;
        p = 64'(k) * 64'(TEA_DELTA);
        return p[31:0];
    endfunction

    function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                            input logic [31:0] ka, input logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

// File: src/tea_in_if.sv
// Input channel: valid/ready handshake carrying one plaintext or ciphertext word.
`timescale 1ns / 1ps
interface tea_in_if;
    import tea_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/tea_out_if.sv
// Output channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps
interface tea_out_if;
    import tea_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/tea_round.sv
// One half-round cell of the TEA chain, with its own pipeline register.
`timescale 1ns / 1ps
module tea_round #(
    parameter logic [31:0] SUM_ENC = 32'h0,
    parameter logic [31:0] SUM_DEC = 32'h0,
    parameter bit          SECOND  = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tea_pkg::t_key i_key,
    input  logic          i_valid,
    output logic          o_ready,
    input  tea_pkg::t_blk i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output tea_pkg::t_blk o_data
);
    import tea_pkg::*;

    logic        r_valid;
    t_blk        r_data;
    t_blk        n_data;
    logic [31:0] sum;
    logic        upd_v0;

    assign sum = (i_data.mode == OP_DECRYPT) ? SUM_DEC : SUM_ENC;
    // first half updates v0 when encrypting, v1 when decrypting; second half the other
    assign upd_v0 = SECOND ? (i_data.mode == OP_DECRYPT) : (i_data.mode == OP_ENCRYPT);

    always_comb begin
        n_data = i_data;
        if (upd_v0) begin
            if (i_data.mode == OP_ENCRYPT) begin
                n_data.v0 = i_data.v0 + tea_mix(i_data.v1, sum, i_key.k0, i_key.k1);
            end else begin
                n_data.v0 = i_data.v0 - tea_mix(i_data.v1, sum, i_key.k0, i_key.k1);
            end
        end else begin
            if (i_data.mode == OP_ENCRYPT) begin
                n_data.v1 = i_data.v1 + tea_mix(i_data.v0, sum, i_key.k2, i_key.k3);
            end else begin
                n_data.v1 = i_data.v1 - tea_mix(i_data.v0, sum, i_key.k2, i_key.k3);
            end
        end
    end

    // empty slots let upstream words move up behind a stall
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: src/tea_block_cipher.sv
// TEA block cipher top level: key registers and a chain of half-round cells.
// Each block is registered in every cell of the chain in turn before its result is valid at the output.
// Throughput: one block per cycle while the output is not stalled; each cell does one Feistel half-round per cycle.
// A stalled output holds the last cell; empty cells upstream keep filling.
// Reset (synchronous, active low) clears the key words and all cell valid bits.
`timescale 1ns / 1ps
module tea_block_cipher #(
    parameter int ROUND_PAIRS = tea_pkg::TEA_ROUND_PAIRS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tea_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    tea_in_if.sink                         i_in,
    tea_out_if.source                      o_out
);
    import tea_pkg::*;

    localparam int NCELL = 2 * ROUND_PAIRS;

    t_key r_key;
    logic s_valid [NCELL+1];
    logic s_ready [NCELL+1];
    t_blk s_data  [NCELL+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KEY0: r_key.k0 <= i_cfg_data;
                REG_KEY1: r_key.k1 <= i_cfg_data;
                REG_KEY2: r_key.k2 <= i_cfg_data;
                REG_KEY3: r_key.k3 <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign s_valid[0]     = i_in.valid;
    assign i_in.ready     = s_ready[0];
    assign s_data[0].mode = t_op'(i_in.data.opcode);
    assign s_data[0].v0   = i_in.data.left_word;
    assign s_data[0].v1   = i_in.data.right_word;
    assign s_data[0].last = i_in.data.last_block;

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        localparam int P = j / 2;
        tea_round #(
            .SUM_ENC (sum_at(P + 1)),
            .SUM_DEC (sum_at(ROUND_PAIRS - P)),
            .SECOND  (bit'(j % 2))
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_valid (s_valid[j]),
            .o_ready (s_ready[j]),
            .i_data  (s_data[j]),
            .o_valid (s_valid[j+1]),
            .i_ready (s_ready[j+1]),
            .o_data  (s_data[j+1])
        );
    end

    assign o_out.valid         = s_valid[NCELL];
    assign s_ready[NCELL]      = o_out.ready;
    assign o_out.data.out_left  = s_data[NCELL].v0;
    assign o_out.data.out_right = s_data[NCELL].v1;
    assign o_out.data.out_last  = s_data[NCELL].last;

endmodule

// File: tb/sv/tea_block_cipher_tb.sv
// Self-checking testbench for the TEA block cipher pipeline.
`timescale 1ns / 1ps
module tea_block_cipher_tb;
    import tea_pkg::*;

    localparam int NUM_KEY_REGS     = 4;
    localparam int PIPE_LATENCY     = 2 * TEA_ROUND_PAIRS;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 200000;

    typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_SPARSE} t_sink_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    tea_in_if  in_if ();
    tea_out_if out_if ();

    tea_block_cipher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [31:0] key_shadow [NUM_KEY_REGS];
    t_in_word    block_feed_q [$];
    t_out_word   cipher_result_q [$];
    int          blocks_queued = 0;
    int          blocks_taken  = 0;
    int          mismatch_cnt  = 0;
    int          cycle_cnt     = 0;
    logic        in_fire       = 1'b0;

    // sender burst/gap shaping
    int          gap_max    = 0;
    int          gap_left   = 0;
    int          burst_left = 1;

    // receiver stall pattern and long hold-off
    t_sink_mode  sink_mode      = SINK_ALWAYS;
    logic [15:0] ready_pattern  = '1;
    int          pattern_pos    = 0;
    logic        long_hold_req  = 1'b0;
    int          long_hold_left = 0;

    function automatic logic [31:0] feistel_f(input logic [31:0] v, input logic [31:0] s,
                                              input logic [31:0] ka, input logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    function automatic t_out_word tea_transform(input t_in_word w);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] s;
        t_out_word   r;
        y = w.left_word;
        z = w.right_word;
        if (w.opcode == OP_ENCRYPT) begin
            s = '0;
            for (int n = 0; n < TEA_ROUND_PAIRS; n++) begin
                s = s + TEA_DELTA;
                y = y + feistel_f(z, s, key_shadow[0], key_shadow[1]);
                z = z + feistel_f(y, s, key_shadow[2], key_shadow[3]);
            end
        end else begin
            s = TEA_DELTA * TEA_ROUND_PAIRS;
            for (int n = 0; n < TEA_ROUND_PAIRS; n++) begin
                z = z - feistel_f(y, s, key_shadow[2], key_shadow[3]);
                y = y - feistel_f(z, s, key_shadow[0], key_shadow[1]);
                s = s - TEA_DELTA;
            end
        end
        r.out_left  = y;
        r.out_right = z;
        r.out_last  = w.last_block;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // ---------------- driver ----------------
    always @(negedge i_clk) begin
        if (in_if.valid && !in_fire) begin
            // word still waiting for ready: hold it
        end else if (gap_left > 0) begin
            in_if.valid <= 1'b0;
            gap_left--;
        end else if (block_feed_q.size() > 0) begin
            in_if.valid <= 1'b1;
            in_if.data  <= block_feed_q.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 32);
                gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // ---------------- receiver ----------------
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_left = LONG_HOLD_CYCLES;
            long_hold_req  = 1'b0;
        end
        if (long_hold_left > 0) begin
            out_if.ready <= 1'b0;
            long_hold_left--;
        end else begin
            out_if.ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_pos++;
            if (pattern_pos == 16) begin
                pattern_pos = 0;
                case (sink_mode)
                    SINK_ALWAYS: ready_pattern = '1;
                    SINK_RANDOM: ready_pattern = 16'($urandom) | 16'h1;
                    SINK_SPARSE: ready_pattern = 16'($urandom & $urandom) | 16'h1;
                    default:     ready_pattern = '1;
                endcase
            end
        end
    end

    // ---------------- monitor ----------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        in_fire = i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (cipher_result_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, out_if.data);
                mismatch_cnt++;
            end else begin
                want = cipher_result_q.pop_front();
                check_field("out_left",  want.out_left,  out_if.data.out_left);
                check_field("out_right", want.out_right, out_if.data.out_right);
                check_field("out_last",  32'(want.out_last), 32'(out_if.data.out_last));
            end
        end
        if (in_fire) begin
            cipher_result_q.push_back(tea_transform(in_if.data));
            blocks_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < NUM_KEY_REGS)
            key_shadow[idx[1:0]] = val;
    endtask

    // four key words, then a stray write to an unmapped index that must be ignored
    task automatic set_keys(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_cfg(REG_KEY0, k0);
        write_cfg(REG_KEY1, k1);
        write_cfg(REG_KEY2, k2);
        write_cfg(REG_KEY3, k3);
        write_cfg(CFG_IDX_W'(NUM_KEY_REGS + $urandom_range(0, 3)), $urandom);
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_block(input t_op op, input logic [31:0] l, input logic [31:0] r,
                               input logic last);
        t_in_word w;
        w.opcode     = op;
        w.left_word  = l;
        w.right_word = r;
        w.last_block = last;
        block_feed_q.push_back(w);
        blocks_queued++;
    endtask

    task automatic queue_directed();
        for (int op = 0; op < 2; op++) begin
            queue_block(t_op'(op), 32'h0000_0000, 32'h0000_0000, 1'b0);
            queue_block(t_op'(op), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
            queue_block(t_op'(op), 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
            queue_block(t_op'(op), 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
            queue_block(t_op'(op), 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
            queue_block(t_op'(op), 32'h8000_0000, 32'h0000_0001, 1'b1);
        end
    endtask

    // random blocks; some are encrypt/decrypt pairs that feed the ciphertext back
    task automatic queue_random(input int count);
        t_in_word  pt;
        t_out_word ct;
        int        n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 3) == 0 && n + 1 < count) begin
                pt.opcode     = OP_ENCRYPT;
                pt.left_word  = rand_word();
                pt.right_word = rand_word();
                pt.last_block = 1'b0;
                ct = tea_transform(pt);
                queue_block(OP_ENCRYPT, pt.left_word, pt.right_word, 1'b0);
                queue_block(OP_DECRYPT, ct.out_left, ct.out_right, 1'b1);
                n += 2;
            end else begin
                queue_block(t_op'($urandom_range(0, 1)), rand_word(), rand_word(),
                            1'($urandom_range(0, 1)));
                n++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (blocks_taken != blocks_queued || cipher_result_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < NUM_KEY_REGS; k++)
            key_shadow[k] = '0;
        i_rst_n      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset keys (all zero), then all-ones keys
        queue_directed();
        wait_idle();
        set_keys('1, '1, '1, '1);
        sink_mode = SINK_RANDOM;
        gap_max   = 3;
        queue_directed();
        wait_idle();

        // receiver holds off long enough to back the pipeline up to the input
        set_keys($urandom, $urandom, $urandom, $urandom);
        sink_mode     = SINK_ALWAYS;
        gap_max       = 0;
        long_hold_req = 1'b1;
        queue_random(150);
        wait_idle();

        set_keys(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        sink_mode = SINK_RANDOM;
        gap_max   = 12;
        queue_random(100);
        wait_idle();

        set_keys(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        sink_mode = SINK_SPARSE;
        gap_max   = 2;
        queue_random(100);
        wait_idle();

        set_keys($urandom, $urandom, $urandom, $urandom);
        sink_mode = SINK_ALWAYS;
        gap_max   = 0;
        queue_random(100);
        wait_idle();

        set_keys(rand_word(), rand_word(), rand_word(), rand_word());
        sink_mode = SINK_RANDOM;
        gap_max   = 6;
        queue_random(100);
        wait_idle();

        repeat (PIPE_LATENCY + 16) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
